// ----- rtl/vac_pkg.sv -----
// Shared types, codes and constants of the vehicle alarm controller.
package vac_pkg;

  localparam int DEBOUNCE_DEPTH_DEFAULT = 4;
  localparam int DUTY_BITS_DEFAULT      = 10;

  localparam int NUM_SENSORS = 4;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 3;
  localparam int TICK_W      = 8;
  localparam int MOVE_W      = 10;
  localparam int SERVO_W     = 11;
  localparam int CFG_INDEX_W = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_POLL_PERIOD    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAMP_STEP      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAMP_INCREMENT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD           = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAP            = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SERVO_MOVE     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_SERVO_NEUTRAL  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_BEEP_DUTY      = 3'd7;

  // Register values after reset.
  localparam int POLL_PERIOD_RESET    = 5;
  localparam int RAMP_STEP_RESET      = 4;
  localparam int RAMP_INCREMENT_RESET = 50;
  localparam int HOLD_RESET           = 60;
  localparam int GAP_RESET            = 40;
  localparam int SERVO_MOVE_RESET     = 200;
  localparam int SERVO_NEUTRAL_RESET  = 1495;
  localparam int BEEP_DUTY_RESET      = 1023;

  // Remote command codes.
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PANIC  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DISARM = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ARM    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WINDOW = 3'd4;

  // Command status codes.
  localparam logic [STATUS_W-1:0] ST_NONE           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DONE           = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REFUSED_SEAT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REFUSED_WINDOW = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REFUSED_ENTRY  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REFUSED_ARMED  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_BUSY           = 3'd6;

  // Sequence timing and servo drive.
  localparam logic [MOVE_W-1:0]  ARM_BEEP_TICKS    = 10'd30;
  localparam logic [MOVE_W-1:0]  FAIL_BEEP_TICKS   = 10'd15;
  localparam logic [1:0]         FAIL_BEEP_COUNT   = 2'd3;
  localparam logic [MOVE_W-1:0]  WINDOW_BEEP_TICKS = 10'd20;
  localparam logic [SERVO_W-1:0] SERVO_DOWN_US     = 11'd1400;
  localparam logic [SERVO_W-1:0] SERVO_UP_US       = 11'd1600;

  typedef enum logic [3:0] {
    SEQ_NONE     = 4'd0,
    SEQ_ARM_BEEP = 4'd1,
    SEQ_FAIL_ON  = 4'd2,
    SEQ_FAIL_OFF = 4'd3,
    SEQ_MOVE     = 4'd4,
    SEQ_WIN_BEEP = 4'd5
  } seq_step_t;

  // Request from the command decoder to the sequencer.
  typedef struct packed {
    logic      start;
    seq_step_t step;
  } seq_req_t;

  // Sequencer status seen by the top level.
  typedef struct packed {
    logic               busy;
    logic               window_lowered;
    logic               window_next;
    logic               buzz_on;
    logic [SERVO_W-1:0] servo;
  } seq_stat_t;

endpackage

// ----- rtl/vehicle_alarm_controller_core.sv -----
// A result passes through the item register and then the result register before it appears on the output.
// Throughput: one item per clock cycle through one registered pass while out_stall is low; while a
// result waits, the item register takes one more transaction before the input stalls.
// Reset (rst, synchronous, active high) clears all flags, histories, counters and sequences,
// loads every configuration register with its documented default, and empties both stages.
// There is no memory and no clearing pass: the block takes items in the cycle after reset.
module vehicle_alarm_controller_core #(
  parameter int DEBOUNCE_DEPTH = vac_pkg::DEBOUNCE_DEPTH_DEFAULT,
  parameter int DUTY_BITS      = vac_pkg::DUTY_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // Item input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [vac_pkg::CMD_W-1:0]       command,
  input  logic                            door_one_level,
  input  logic                            door_two_level,
  input  logic                            trunk_level,
  input  logic                            seat_level,
  // Result output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [DUTY_BITS-1:0]            buzzer_duty,
  output logic [vac_pkg::SERVO_W-1:0]     servo_pulse_us,
  output logic                            armed_led,
  output logic                            intrusion_led,
  output logic                            alarm_on,
  output logic                            window_is_down,
  output logic [vac_pkg::STATUS_W-1:0]    command_status,
  // Configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vac_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [((DUTY_BITS > vac_pkg::SERVO_W) ? DUTY_BITS : vac_pkg::SERVO_W)-1:0] cfg_data
);
  import vac_pkg::*;

  // Configuration registers. Writes are always taken; the user must issue them only while idle (not enforced).
  logic [TICK_W-1:0]    poll_period_ticks;
  logic [TICK_W-1:0]    ramp_step_ticks;
  logic [DUTY_BITS-1:0] ramp_increment;
  logic [TICK_W-1:0]    hold_ticks;
  logic [TICK_W-1:0]    gap_ticks;
  logic [MOVE_W-1:0]    servo_move_ticks;
  logic [SERVO_W-1:0]   servo_neutral_us;
  logic [DUTY_BITS-1:0] beep_duty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_period_ticks <= TICK_W'(POLL_PERIOD_RESET);
      ramp_step_ticks   <= TICK_W'(RAMP_STEP_RESET);
      ramp_increment    <= DUTY_BITS'(RAMP_INCREMENT_RESET);
      hold_ticks        <= TICK_W'(HOLD_RESET);
      gap_ticks         <= TICK_W'(GAP_RESET);
      servo_move_ticks  <= MOVE_W'(SERVO_MOVE_RESET);
      servo_neutral_us  <= SERVO_W'(SERVO_NEUTRAL_RESET);
      beep_duty         <= DUTY_BITS'(BEEP_DUTY_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POLL_PERIOD:    poll_period_ticks <= cfg_data[TICK_W-1:0];
        CFG_RAMP_STEP:      ramp_step_ticks   <= cfg_data[TICK_W-1:0];
        CFG_RAMP_INCREMENT: ramp_increment    <= cfg_data[DUTY_BITS-1:0];
        CFG_HOLD:           hold_ticks        <= cfg_data[TICK_W-1:0];
        CFG_GAP:            gap_ticks         <= cfg_data[TICK_W-1:0];
        CFG_SERVO_MOVE:     servo_move_ticks  <= cfg_data[MOVE_W-1:0];
        CFG_SERVO_NEUTRAL:  servo_neutral_us  <= cfg_data[SERVO_W-1:0];
        CFG_BEEP_DUTY:      beep_duty         <= cfg_data[DUTY_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Item register. An item is processed when the result register is free or being emptied;
  // the item register itself can then take the next transaction in the same cycle.
  logic             item_valid;
  logic [CMD_W-1:0] item_command;
  logic             item_door_one, item_door_two, item_trunk, item_seat;
  logic             advance;

  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_command  <= command;
      item_door_one <= door_one_level;
      item_door_two <= door_two_level;
      item_trunk    <= trunk_level;
      item_seat     <= seat_level;
    end
  end

  // Alarm state held here; the sequencer keeps the window position.
  logic                      armed, alarm, breakin;
  logic [DEBOUNCE_DEPTH-1:0] history [NUM_SENSORS];
  logic [TICK_W-1:0]         poll_counter;

  seq_req_t  seq_req;
  seq_stat_t seq_stat;

  logic                      armed_cmd, alarm_cmd, breakin_cmd;
  logic [STATUS_W-1:0]       status;
  logic                      entry_open;
  logic                      sample_now, hit;
  logic                      sample [NUM_SENSORS];
  logic [DEBOUNCE_DEPTH-1:0] history_next [NUM_SENSORS];
  logic                      armed_next, alarm_next, breakin_next;
  logic [TICK_W-1:0]         poll_inc, poll_counter_next;
  logic [DUTY_BITS-1:0]      siren_duty;

  // Command handling: acts on the state left by the previous item.
  always_comb begin
    armed_cmd    = armed;
    alarm_cmd    = alarm;
    breakin_cmd  = breakin;
    status       = ST_NONE;
    seq_req.start = 1'b0;
    seq_req.step  = SEQ_NONE;
    entry_open   = item_door_one || item_door_two || item_trunk;
    if (item_command inside {[CMD_PANIC:CMD_WINDOW]}) begin
      if (seq_stat.busy) begin
        status = ST_BUSY;
      end else begin
        case (item_command)
          CMD_PANIC: begin
            alarm_cmd = 1'b1;
            status    = ST_DONE;
          end
          CMD_DISARM: begin
            alarm_cmd   = 1'b0;
            armed_cmd   = 1'b0;
            breakin_cmd = 1'b0;
            status      = ST_DONE;
          end
          CMD_ARM: begin
            seq_req.start = 1'b1;
            if (!entry_open && !seq_stat.window_lowered && !item_seat) begin
              armed_cmd    = 1'b1;
              seq_req.step = SEQ_ARM_BEEP;
              status       = ST_DONE;
            end else begin
              armed_cmd    = 1'b0;
              seq_req.step = SEQ_FAIL_ON;
              if (item_seat) begin
                status = ST_REFUSED_SEAT;
              end else if (seq_stat.window_lowered) begin
                status = ST_REFUSED_WINDOW;
              end else begin
                status = ST_REFUSED_ENTRY;
              end
            end
          end
          CMD_WINDOW: begin
            if (armed) begin
              status = ST_REFUSED_ARMED;
            end else begin
              seq_req.start = 1'b1;
              seq_req.step  = SEQ_MOVE;
              status        = ST_DONE;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Debounce poll: on a poll tick every level shifts into its history, and a full history of
  // ones while armed and quiet raises the alarm and latches the break-in flag.
  always_comb begin
    sample_now = (poll_counter == '0);
    sample[0]  = item_door_one;
    sample[1]  = item_door_two;
    sample[2]  = item_trunk;
    sample[3]  = seq_stat.window_lowered;
    hit        = 1'b0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      history_next[i] = sample_now ? DEBOUNCE_DEPTH'({history[i], sample[i]}) : history[i];
      if (sample_now && (&history_next[i])) begin
        hit = 1'b1;
      end
    end
    armed_next   = armed_cmd;
    alarm_next   = alarm_cmd;
    breakin_next = breakin_cmd;
    if (armed_cmd && !alarm_cmd && hit) begin
      alarm_next   = 1'b1;
      breakin_next = 1'b1;
    end
    poll_inc          = poll_counter + TICK_W'(1);
    poll_counter_next = (poll_inc >= poll_period_ticks) ? '0 : poll_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed        <= 1'b0;
      alarm        <= 1'b0;
      breakin      <= 1'b0;
      poll_counter <= '0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        history[i] <= '0;
      end
    end else if (advance) begin
      armed        <= armed_next;
      alarm        <= alarm_next;
      breakin      <= breakin_next;
      poll_counter <= poll_counter_next;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        history[i] <= history_next[i];
      end
    end
  end

  // The siren sees the alarm after the poll, so it falls silent in the tick the alarm clears.
  vac_siren #(
    .DUTY_BITS (DUTY_BITS)
  ) u_siren (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .alarm           (alarm_next),
    .ramp_step_ticks (ramp_step_ticks),
    .ramp_increment  (ramp_increment),
    .hold_ticks      (hold_ticks),
    .gap_ticks       (gap_ticks),
    .duty            (siren_duty)
  );

  vac_seq u_seq (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .req              (seq_req),
    .servo_move_ticks (servo_move_ticks),
    .servo_neutral_us (servo_neutral_us),
    .stat             (seq_stat)
  );

  // Result register. A feedback beep takes precedence over the siren.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      buzzer_duty    <= seq_stat.buzz_on ? beep_duty : siren_duty;
      servo_pulse_us <= seq_stat.servo;
      armed_led      <= armed_next;
      intrusion_led  <= breakin_next;
      alarm_on       <= alarm_next;
      window_is_down <= seq_stat.window_next;
      command_status <= status;
    end
  end

endmodule

// ----- rtl/vac_siren.sv -----
// Sawtooth siren generator: ramp, hold at full duty, silent gap.
module vac_siren #(
  parameter int DUTY_BITS = vac_pkg::DUTY_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic                      alarm,
  input  logic [vac_pkg::TICK_W-1:0] ramp_step_ticks,
  input  logic [DUTY_BITS-1:0]      ramp_increment,
  input  logic [vac_pkg::TICK_W-1:0] hold_ticks,
  input  logic [vac_pkg::TICK_W-1:0] gap_ticks,
  output logic [DUTY_BITS-1:0]      duty
);
  import vac_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RAMP = 2'd1,
    PH_HOLD = 2'd2,
    PH_GAP  = 2'd3
  } siren_phase_t;

  localparam logic [DUTY_BITS:0] FULL_DUTY = {1'b0, {DUTY_BITS{1'b1}}};

  siren_phase_t       phase, phase_next, phase_cur;
  logic [DUTY_BITS:0] level, level_next, level_cur, level_sum;
  logic [TICK_W-1:0]  timer, timer_next, timer_inc;

  always_comb begin
    phase_cur  = (phase == PH_IDLE) ? PH_RAMP : phase;
    level_cur  = (phase == PH_IDLE) ? '0 : level;
    timer_inc  = ((phase == PH_IDLE) ? '0 : timer) + TICK_W'(1);
    level_sum  = level_cur + {1'b0, ramp_increment};
    phase_next = phase_cur;
    level_next = level_cur;
    timer_next = timer_inc;
    duty       = '0;
    if (!alarm) begin
      phase_next = PH_IDLE;
      level_next = '0;
      timer_next = '0;
    end else begin
      case (phase_cur)
        PH_RAMP: begin
          duty = level_cur[DUTY_BITS-1:0];
          if (timer_inc >= ramp_step_ticks) begin
            timer_next = '0;
            level_next = level_sum;
            if (level_sum > FULL_DUTY) begin
              phase_next = PH_HOLD;
            end
          end
        end
        PH_HOLD: begin
          duty = FULL_DUTY[DUTY_BITS-1:0];
          if (timer_inc >= hold_ticks) begin
            timer_next = '0;
            phase_next = PH_GAP;
          end
        end
        PH_GAP: begin
          if (timer_inc >= gap_ticks) begin
            timer_next = '0;
            level_next = '0;
            phase_next = PH_RAMP;
          end
        end
        default: begin
          phase_next = PH_IDLE;
          level_next = '0;
          timer_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      level <= '0;
      timer <= '0;
    end else if (advance) begin
      phase <= phase_next;
      level <= level_next;
      timer <= timer_next;
    end
  end

endmodule

// ----- rtl/vac_seq.sv -----
// Timed feedback sequences: beeps and the window servo move.
module vac_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  vac_pkg::seq_req_t           req,
  input  logic [vac_pkg::MOVE_W-1:0]  servo_move_ticks,
  input  logic [vac_pkg::SERVO_W-1:0] servo_neutral_us,
  output vac_pkg::seq_stat_t          stat
);
  import vac_pkg::*;

  seq_step_t         step, step_next, step_cur;
  logic [MOVE_W-1:0] timer, timer_next, timer_inc;
  logic [1:0]        beeps, beeps_next, beeps_cur, beeps_inc;
  logic              window_lowered, window_next;

  always_comb begin
    step_cur    = req.start ? req.step : step;
    timer_inc   = (req.start ? '0 : timer) + MOVE_W'(1);
    beeps_cur   = req.start ? 2'd0 : beeps;
    beeps_inc   = beeps_cur + 2'd1;
    step_next   = step_cur;
    timer_next  = timer_inc;
    beeps_next  = beeps_cur;
    window_next = window_lowered;
    stat.buzz_on = 1'b0;
    stat.servo   = servo_neutral_us;
    case (step_cur)
      SEQ_ARM_BEEP: begin
        stat.buzz_on = 1'b1;
        if (timer_inc >= ARM_BEEP_TICKS) begin
          step_next  = SEQ_NONE;
          timer_next = '0;
          beeps_next = '0;
        end
      end
      SEQ_FAIL_ON: begin
        stat.buzz_on = 1'b1;
        if (timer_inc >= FAIL_BEEP_TICKS) begin
          step_next  = SEQ_FAIL_OFF;
          timer_next = '0;
        end
      end
      SEQ_FAIL_OFF: begin
        if (timer_inc >= FAIL_BEEP_TICKS) begin
          timer_next = '0;
          if (beeps_inc >= FAIL_BEEP_COUNT) begin
            step_next  = SEQ_NONE;
            beeps_next = '0;
          end else begin
            step_next  = SEQ_FAIL_ON;
            beeps_next = beeps_inc;
          end
        end
      end
      SEQ_MOVE: begin
        stat.servo = window_lowered ? SERVO_UP_US : SERVO_DOWN_US;
        if (timer_inc >= servo_move_ticks) begin
          window_next = !window_lowered;
          step_next   = SEQ_WIN_BEEP;
          timer_next  = '0;
          beeps_next  = '0;
        end
      end
      SEQ_WIN_BEEP: begin
        stat.buzz_on = 1'b1;
        if (timer_inc >= WINDOW_BEEP_TICKS) begin
          step_next  = SEQ_NONE;
          timer_next = '0;
          beeps_next = '0;
        end
      end
      default: begin
        step_next  = SEQ_NONE;
        timer_next = '0;
        beeps_next = '0;
      end
    endcase
    stat.busy           = (step != SEQ_NONE);
    stat.window_lowered = window_lowered;
    stat.window_next    = window_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step           <= SEQ_NONE;
      timer          <= '0;
      beeps          <= '0;
      window_lowered <= 1'b0;
    end else if (advance) begin
      step           <= step_next;
      timer          <= timer_next;
      beeps          <= beeps_next;
      window_lowered <= window_next;
    end
  end

endmodule
